// File: rtl/delayed_squelch_gate_defines.svh
// Assertion macros used by the checker of the squelch gate.
`ifndef DELAYED_SQUELCH_GATE_DEFINES_SVH
`define DELAYED_SQUELCH_GATE_DEFINES_SVH

// Condition that must hold at every clock edge out of reset.
`define DSG_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Same-cycle implication.
`define DSG_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define DSG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/dsg_pkg.sv
package dsg_pkg;

  // Delay depth must be a power of two: the read-back address wraps as a plain
  // circular memory address.
  localparam int DELAY_DEPTH    = 32768;
  localparam int ADDR_BITS      = $clog2(DELAY_DEPTH);
  localparam int FILL_BITS      = ADDR_BITS + 1;
  localparam int SAMPLE_BITS    = 16;
  localparam int LEVEL_BITS     = 32;
  localparam int GATE_BITS      = 15;
  localparam int COUNT_BITS     = GATE_BITS + 1;
  localparam int CFG_INDEX_BITS = 4;
  localparam int CFG_DATA_BITS  = 32;

  localparam logic [LEVEL_BITS-1:0] LEVEL_RESET = 32'd429497;

  // Register indexes on the configuration port.
  localparam logic [CFG_INDEX_BITS-1:0] REG_LEVEL = 4'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_GATE  = 4'd1;

  // Per-word info handed from the control stage to the output stage.
  typedef struct packed {
    logic [SAMPLE_BITS-1:0] data;     // sample, or zero when quiet
    logic                   open;     // squelch state after this word
    logic                   delayed;  // gate nonzero: take result from delay line
    logic                   hit;      // read-back entry has been written since reset
    logic                   fwd;      // read-back entry is the one written now
  } issue_t;

endpackage

// File: rtl/dsg_delay_ram.sv
module dsg_delay_ram #(
  parameter int ADDR_BITS = 15,
  parameter int DATA_BITS = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [DATA_BITS-1:0] wdata,
  input  logic                 re,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [DATA_BITS-1:0] rdata
);

  logic [DATA_BITS-1:0] mem [2**ADDR_BITS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/dsg_ctrl.sv
module dsg_ctrl (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  input  logic [dsg_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [dsg_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  input  logic                                 accept,
  input  logic signed [dsg_pkg::SAMPLE_BITS-1:0] demod_sample,
  input  logic [dsg_pkg::LEVEL_BITS-1:0]       avg_power,
  output logic                                 mem_we,
  output logic [dsg_pkg::ADDR_BITS-1:0]        mem_waddr,
  output logic [dsg_pkg::SAMPLE_BITS-1:0]      mem_wdata,
  output logic                                 mem_re,
  output logic [dsg_pkg::ADDR_BITS-1:0]        mem_raddr,
  output dsg_pkg::issue_t                      issue
);

  import dsg_pkg::*;

  logic [LEVEL_BITS-1:0]         level;
  logic [GATE_BITS-1:0]          gate;
  logic [COUNT_BITS-1:0]         count;
  logic [COUNT_BITS-1:0]         count_next;
  logic [ADDR_BITS-1:0]          wp;
  logic [FILL_BITS-1:0]          fill;
  logic [FILL_BITS-1:0]          fill_next;
  logic [ADDR_BITS+GATE_BITS-1:0] gate_wide;
  logic [ADDR_BITS-1:0]          back;
  logic                          loud;
  logic                          delayed;

  always_comb begin
    loud      = avg_power > level;
    delayed   = gate != '0;
    gate_wide = {{ADDR_BITS{1'b0}}, gate};
    back      = wp - gate_wide[ADDR_BITS-1:0];

    count_next = count;
    if (loud) begin
      if (count < {gate, 1'b0}) count_next = count + 1'b1;
    end else begin
      if (count != '0) count_next = count - 1'b1;
    end

    // Writes go in address order from zero, so fill tells which entries hold data.
    fill_next = fill[ADDR_BITS] ? fill : fill + 1'b1;

    issue.data    = loud ? demod_sample : '0;
    issue.delayed = delayed;
    issue.open    = delayed ? (count_next > {1'b0, gate}) : loud;
    issue.fwd     = back == wp;
    issue.hit     = issue.fwd || fill[ADDR_BITS] || ({1'b0, back} < fill);
  end

  // Read and write addresses differ unless the gate is a multiple of the depth;
  // that case is forwarded in the output stage.
  assign mem_we    = accept && delayed;
  assign mem_waddr = wp;
  assign mem_wdata = issue.data;
  assign mem_re    = accept && delayed;
  assign mem_raddr = back;

  always_ff @(posedge clk) begin
    if (rst) begin
      level <= LEVEL_RESET;
      gate  <= '0;
      count <= '0;
      wp    <= '0;
      fill  <= '0;
    end else begin
      if (accept && delayed) begin
        count <= count_next;
        wp    <= wp + 1'b1;
        fill  <= fill_next;
      end
      if (cfg_valid) begin
        priority if (cfg_index == REG_LEVEL) begin
          level <= cfg_data[LEVEL_BITS-1:0];
        end else if (cfg_index == REG_GATE) begin
          gate  <= cfg_data[GATE_BITS-1:0];
          count <= '0;
        end
      end
    end
  end

endmodule

// File: rtl/dsg_out.sv
module dsg_out (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  output logic                                   accept,
  input  dsg_pkg::issue_t                        issue,
  input  logic [dsg_pkg::SAMPLE_BITS-1:0]        rdata,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [dsg_pkg::SAMPLE_BITS-1:0] gated_sample,
  output logic                                   squelch_open
);

  import dsg_pkg::*;

  logic                   s1_valid;
  issue_t                 s1;
  logic                   advance;
  logic [SAMPLE_BITS-1:0] result;

  assign advance  = !out_valid || out_ready;
  assign in_ready = !s1_valid || advance;
  assign accept   = in_valid && in_ready;

  always_comb begin
    priority if (!s1.delayed) begin
      result = s1.data;
    end else if (!s1.open) begin
      result = '0;
    end else if (s1.fwd) begin
      result = s1.data;
    end else if (s1.hit) begin
      result = rdata;
    end else begin
      result = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) s1_valid <= in_valid;
      if (advance) out_valid <= s1_valid;
    end
  end

  // rdata only updates on accept, so it holds while s1 waits
  always_ff @(posedge clk) begin
    if (accept) s1 <= issue;
    if (advance && s1_valid) begin
      gated_sample <= result;
      squelch_open <= s1.open;
    end
  end

endmodule

// File: rtl/delayed_squelch_gate.sv
// Delayed squelch gate. Takes one demodulated sample with its averaged power
// per word and returns one gated sample with the squelch state per word, at a
// sustained rate of one word per clock unless the output stalls; a taken
// word passes the registered delay-memory read and then the output register.
// The rate is set by the delay memory, which serves one write and one read each
// cycle. Power is compared with the level by a strict greater-than. With a gate
// of zero the squelch follows that test directly. Otherwise an open counter
// saturating at 0 and twice the gate decides, and the output is the
// (quiet-zeroed) sample from gate words earlier. Writing the gate register
// clears the counter. The delay memory needs no clearing pass after reset: a
// fill count marks which entries have been written and the others read as zero,
// so words are taken from the first cycle out of reset. The user must write
// configuration only while the block is idle; the block does not enforce it.
module delayed_squelch_gate (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [dsg_pkg::SAMPLE_BITS-1:0] demod_sample,
  input  logic [dsg_pkg::LEVEL_BITS-1:0]         avg_power,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [dsg_pkg::SAMPLE_BITS-1:0] gated_sample,
  output logic                                   squelch_open,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [dsg_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
  input  logic [dsg_pkg::CFG_DATA_BITS-1:0]      cfg_data
);

  import dsg_pkg::*;

  logic                   accept;
  issue_t                 issue;
  logic                   mem_we;
  logic [ADDR_BITS-1:0]   mem_waddr;
  logic [SAMPLE_BITS-1:0] mem_wdata;
  logic                   mem_re;
  logic [ADDR_BITS-1:0]   mem_raddr;
  logic [SAMPLE_BITS-1:0] mem_rdata;

  assign cfg_ready = 1'b1;

  dsg_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .accept       (accept),
    .demod_sample (demod_sample),
    .avg_power    (avg_power),
    .mem_we       (mem_we),
    .mem_waddr    (mem_waddr),
    .mem_wdata    (mem_wdata),
    .mem_re       (mem_re),
    .mem_raddr    (mem_raddr),
    .issue        (issue)
  );

  dsg_delay_ram #(
    .ADDR_BITS (ADDR_BITS),
    .DATA_BITS (SAMPLE_BITS)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  dsg_out u_out (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .accept       (accept),
    .issue        (issue),
    .rdata        (mem_rdata),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .gated_sample (gated_sample),
    .squelch_open (squelch_open)
  );

endmodule

// File: rtl/dsg_checker.sv
`include "delayed_squelch_gate_defines.svh"

module dsg_checker (
  input logic                                   clk,
  input logic                                   rst,
  input logic                                   in_valid,
  input logic                                   in_ready,
  input logic                                   out_valid,
  input logic                                   out_ready,
  input logic signed [dsg_pkg::SAMPLE_BITS-1:0] gated_sample,
  input logic                                   squelch_open
);

  `DSG_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(gated_sample) && $stable(squelch_open), "output word changed while stalled")

  `DSG_ASSERT_IMPLY(a_closed_zero, out_valid && !squelch_open, gated_sample == '0, "closed squelch with nonzero sample")

  `DSG_ASSERT_IMPLY(a_rise_latency, $rose(out_valid), $past(in_valid && in_ready, 2), "output word without input two cycles earlier")

  `DSG_ASSERT_IMPLY(a_stall_cause, !in_ready, out_valid && !out_ready, "input stalled without output backpressure")

endmodule

bind delayed_squelch_gate dsg_checker u_dsg_checker (.*);

// File: tb/tb_delayed_squelch_gate.sv
module tb_delayed_squelch_gate;
  timeunit 1ns;
  timeprecision 1ps;

  import dsg_pkg::*;

  localparam logic [CFG_INDEX_BITS-1:0] REG_NONE = 4'hF;  // unmapped index
  localparam int RANDOM_WORDS = 1100;
  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_PAUSE  = 4;

  typedef enum logic {ROW_WORD, ROW_CFG} row_kind_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          open;
  } gate_word_t;

  typedef struct packed {
    row_kind_t                     kind;
    logic [CFG_INDEX_BITS-1:0]     index;
    logic [CFG_DATA_BITS-1:0]      data;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic [LEVEL_BITS-1:0]         power;
    logic                          known;
    logic signed [SAMPLE_BITS-1:0] want_sample;
    logic                          want_open;
  } stim_row_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic signed [SAMPLE_BITS-1:0] demod_sample = '0;
  logic [LEVEL_BITS-1:0]         avg_power = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic signed [SAMPLE_BITS-1:0] gated_sample;
  logic                          squelch_open;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [CFG_INDEX_BITS-1:0]     cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]      cfg_data = '0;

  delayed_squelch_gate dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .demod_sample (demod_sample),
    .avg_power    (avg_power),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .gated_sample (gated_sample),
    .squelch_open (squelch_open),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Shadow state of the gate
  logic [LEVEL_BITS-1:0]  sh_level;
  logic [GATE_BITS-1:0]   sh_gate;
  logic [COUNT_BITS-1:0]  sh_count;
  logic [ADDR_BITS-1:0]   sh_wptr;
  logic                   sh_open;
  logic [SAMPLE_BITS-1:0] sh_line [DELAY_DEPTH];

  gate_word_t gated_due[$];
  gate_word_t pin_word;
  logic       pin_known = 1'b0;

  int errors = 0;
  int words_checked = 0;
  int opens_seen = 0;
  int reg_writes = 0;
  int idle_cycles = 0;
  bit burst_mode = 1'b0;

  function automatic gate_word_t squelch_step(logic signed [SAMPLE_BITS-1:0] s,
                                              logic [LEVEL_BITS-1:0] p);
    gate_word_t w;
    logic loud;
    logic [ADDR_BITS-1:0] back;
    logic [COUNT_BITS-1:0] cap;
    loud = p > sh_level;
    w.sample = '0;
    if (sh_gate == '0) begin
      sh_open = loud;
      if (loud) w.sample = s;
    end else begin
      cap = {sh_gate, 1'b0};
      if (loud) begin
        if (sh_count < cap) sh_count = sh_count + 1'b1;
        sh_line[sh_wptr] = s;
      end else begin
        if (sh_count != '0) sh_count = sh_count - 1'b1;
        sh_line[sh_wptr] = '0;
      end
      sh_open = sh_count > {1'b0, sh_gate};
      back = sh_wptr - sh_gate;  // depth is a power of two, wraps naturally
      if (sh_open) w.sample = sh_line[back];
      sh_wptr = sh_wptr + 1'b1;
    end
    w.open = sh_open;
    return w;
  endfunction

  initial begin
    sh_level = LEVEL_RESET;
    sh_gate  = '0;
    sh_count = '0;
    sh_wptr  = '0;
    sh_open  = 1'b0;
    for (int i = 0; i < DELAY_DEPTH; i++) sh_line[i] = '0;
  end

  always @(posedge clk) begin : watch
    gate_word_t w;
    gate_word_t got;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        reg_writes++;
        case (cfg_index)
          REG_LEVEL: sh_level = cfg_data[LEVEL_BITS-1:0];
          REG_GATE: begin
            sh_gate  = cfg_data[GATE_BITS-1:0];
            sh_count = '0;
          end
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        w = squelch_step(demod_sample, avg_power);
        if (pin_known) w = pin_word;
        gated_due = {gated_due, w};
      end
      if (out_valid && out_ready) begin
        got.sample = gated_sample;
        got.open   = squelch_open;
        if (gated_due.size() == 0) begin
          $display("%0t: unexpected word sample %0d open %0b", $time, got.sample, got.open);
          errors++;
        end else begin
          w = gated_due.pop_front();
          words_checked++;
          if (got.open) opens_seen++;
          if (got.sample !== w.sample) begin
            $display("%0t: gated_sample expected %0d got %0d", $time, w.sample, got.sample);
            errors++;
          end
          if (got.open !== w.open) begin
            $display("%0t: squelch_open expected %0b got %0b", $time, w.open, got.open);
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles == STALL_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles, %0d words pending",
               STALL_LIMIT, gated_due.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  // Sink side: random back-pressure, with calm stretches
  initial begin : sink
    int stall_left;
    int calm_left;
    bit calm;
    stall_left = 0;
    calm_left  = 0;
    calm       = 1'b0;
    forever begin
      @(negedge clk);
      if (calm_left == 0) begin
        calm_left = 256;
        calm = $urandom_range(0, 9) < 3;
      end else begin
        calm_left--;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready = 1'b0;
      end else begin
        out_ready = 1'b1;
        if (!calm && $urandom_range(0, 99) < 25)
          stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 50)
                                                     : $urandom_range(1, 3);
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (burst_mode || r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [LEVEL_BITS-1:0] pick_power(bit loud, logic [LEVEL_BITS-1:0] lvl);
    longint unsigned span;
    if ($urandom_range(0, 99) < 5) return $urandom;
    if (loud && lvl != '1) begin
      span = 64'hFFFF_FFFF - lvl;
      return lvl + 1 + ($urandom % span);
    end
    if ($urandom_range(0, 9) == 0) return lvl;
    span = longint'(lvl) + 1;
    return $urandom % span;
  endfunction

  // Entered and left at a falling edge; valid stays high across back-to-back words.
  task automatic send_word(logic signed [SAMPLE_BITS-1:0] s, logic [LEVEL_BITS-1:0] p,
                           logic known, gate_word_t want);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    demod_sample = s;
    avg_power    = p;
    pin_known    = known;
    pin_word     = want;
    in_valid     = 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
    in_valid = 1'b0;
    while (gated_due.size() != 0) @(negedge clk);
    repeat (DRAIN_PAUSE) @(negedge clk);
    cfg_index = idx;
    cfg_data  = val;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  stim_row_t dir_rows [33] = '{
    // reset level, gate zero: direct path, strict compare
    '{ROW_WORD, '0, '0, 16'sh7FFF, 32'd429497, 1'b1, 16'sh0000, 1'b0},
    '{ROW_WORD, '0, '0, 16'sh7FFF, 32'd429498, 1'b1, 16'sh7FFF, 1'b1},
    '{ROW_WORD, '0, '0, 16'sh8000, 32'hFFFF_FFFF, 1'b1, 16'sh8000, 1'b1},
    '{ROW_WORD, '0, '0, 16'sh8000, 32'd0, 1'b1, 16'sh0000, 1'b0},
    '{ROW_CFG, REG_LEVEL, 32'd0, '0, '0, 1'b0, '0, 1'b0},
    '{ROW_WORD, '0, '0, 16'sd12345, 32'd0, 1'b1, 16'sh0000, 1'b0},
    '{ROW_WORD, '0, '0, 16'shFFFF, 32'd1, 1'b1, 16'shFFFF, 1'b1},
    '{ROW_CFG, REG_LEVEL, 32'hFFFF_FFFF, '0, '0, 1'b0, '0, 1'b0},
    '{ROW_WORD, '0, '0, 16'sh7FFF, 32'hFFFF_FFFF, 1'b1, 16'sh0000, 1'b0},
    // unmapped index must not touch the level
    '{ROW_CFG, REG_NONE, 32'd5, '0, '0, 1'b0, '0, 1'b0},
    '{ROW_WORD, '0, '0, 16'sh0001, 32'hFFFF_FFFF, 1'b1, 16'sh0000, 1'b0},
    '{ROW_CFG, REG_LEVEL, 32'd1000, '0, '0, 1'b0, '0, 1'b0},
    // upper data bits ignored: gate 2
    '{ROW_CFG, REG_GATE, 32'hFFFF_8002, '0, '0, 1'b0, '0, 1'b0},
    '{ROW_WORD, '0, '0, 16'sd100, 32'd2000, 1'b0, '0, 1'b0},
    '{ROW_WORD, '0, '0, 16'sd200, 32'd2000, 1'b0, '0, 1'b0},
    '{ROW_WORD, '0, '0, 16'sd300, 32'd2000, 1'b0, '0, 1'b0},
    '{ROW_WORD, '0, '0, -16'sd400, 32'd5, 1'b0, '0, 1'b0},
    '{ROW_WORD, '0, '0, 16'sd500, 32'd2000, 1'b0, '0, 1'b0},
    '{ROW_WORD, '0, '0, 16'sh7FFF, 32'd1001, 1'b0, '0, 1'b0},
    // same gate again still clears the counter
    '{ROW_CFG, REG_GATE, 32'd2, '0, '0, 1'b0, '0, 1'b0},
    '{ROW_WORD, '0, '0, 16'sd600, 32'd2000, 1'b1, 16'sh0000, 1'b0},
    '{ROW_CFG, REG_GATE, 32'h0000_7FFF, '0, '0, 1'b0, '0, 1'b0},
    '{ROW_WORD, '0, '0, 16'sh8000, 32'hFFFF_FFFF, 1'b1, 16'sh0000, 1'b0},
    '{ROW_WORD, '0, '0, 16'sh7FFF, 32'd0, 1'b1, 16'sh0000, 1'b0},
    '{ROW_CFG, REG_GATE, 32'd1, '0, '0, 1'b0, '0, 1'b0},
    '{ROW_WORD, '0, '0, 16'sd11, 32'd1001, 1'b0, '0, 1'b0},
    '{ROW_WORD, '0, '0, 16'sd22, 32'd1001, 1'b0, '0, 1'b0},
    '{ROW_WORD, '0, '0, 16'sd33, 32'd1000, 1'b0, '0, 1'b0},
    '{ROW_WORD, '0, '0, 16'sd44, 32'd1001, 1'b0, '0, 1'b0},
    '{ROW_WORD, '0, '0, 16'sh8000, 32'd1001, 1'b0, '0, 1'b0},
    '{ROW_WORD, '0, '0, 16'sh7FFF, 32'd1001, 1'b0, '0, 1'b0},
    '{ROW_WORD, '0, '0, 16'shFFFF, 32'd999, 1'b0, '0, 1'b0},
    '{ROW_WORD, '0, '0, 16'sh0000, 32'd1001, 1'b0, '0, 1'b0}
  };

  initial begin : stim
    int sent;
    int plen;
    int loud_pct;
    int r;
    logic [LEVEL_BITS-1:0] lvl;
    logic [GATE_BITS-1:0]  gate;
    logic signed [SAMPLE_BITS-1:0] s;
    gate_word_t want;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        write_reg(dir_rows[i].index, dir_rows[i].data);
      end else begin
        want.sample = dir_rows[i].want_sample;
        want.open   = dir_rows[i].want_open;
        send_word(dir_rows[i].sample, dir_rows[i].power, dir_rows[i].known, want);
      end
    end

    lvl  = 32'd1000;
    gate = 15'd1;
    want = '0;
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      r = $urandom_range(0, 3);
      if (r != 1) begin
        case ($urandom_range(0, 5))
          0: lvl = '0;
          1: lvl = '1;
          2: lvl = $urandom;
          3: lvl = $urandom_range(0, 65535);
          4: lvl = LEVEL_RESET;
          default: lvl = $urandom >> 8;
        endcase
        write_reg(REG_LEVEL, lvl);
      end
      if (r != 2) begin
        r = $urandom_range(0, 99);
        if (r < 15)      gate = '0;
        else if (r < 80) gate = $urandom_range(1, 8);
        else if (r < 92) gate = $urandom_range(9, 150);
        else if (r < 97) gate = $urandom;
        else             gate = '1;
        write_reg(REG_GATE, {$urandom} << GATE_BITS | gate);
      end
      if ($urandom_range(0, 9) == 0)
        write_reg($urandom_range(REG_GATE + 1, REG_NONE), $urandom);

      if (gate <= 8)        plen = $urandom_range(20, 120);
      else if (gate <= 150) plen = 2 * gate + $urandom_range(20, 60);
      else                  plen = $urandom_range(30, 60);
      loud_pct   = $urandom_range(10, 95);
      burst_mode = $urandom_range(0, 3) == 0;

      repeat (plen) begin
        case ($urandom_range(0, 19))
          0: s = 16'sh8000;
          1: s = 16'sh7FFF;
          default: s = $urandom;
        endcase
        send_word(s, pick_power($urandom_range(0, 99) < loud_pct, lvl), 1'b0, want);
        sent++;
      end
    end
    in_valid = 1'b0;
    burst_mode = 1'b0;

    while (gated_due.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);

    $display("checked %0d gated words (%0d with squelch open) across %0d register writes",
             words_checked, opens_seen, reg_writes);
    $display("levels and gates covered zero, full scale and wrap of the delay line");
    if (errors == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

// File: delayed_squelch_gate.f
+incdir+rtl
rtl/dsg_pkg.sv
rtl/dsg_delay_ram.sv
rtl/dsg_ctrl.sv
rtl/dsg_out.sv
rtl/delayed_squelch_gate.sv
rtl/dsg_checker.sv
tb/tb_delayed_squelch_gate.sv
